// ===== design/utf8_to_utf16_transcoder_defines.svh =====
// Assertion macros used by the transcoder back end.
// Each macro expects clk and rst_n in scope; msg is a string literal.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// Same-cycle implication
`define U8U16_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/u8u16_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

    // Code unit and code point constants
    localparam logic [15:0] REPL_CHAR      = 16'hFFFD;
    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
    localparam logic [20:0] SUPP_BASE      = 21'h10000;

    // Lead byte bounds and the leads with a narrowed second byte
    localparam logic [7:0] ASCII_MAX     = 8'h7F;
    localparam logic [7:0] LEAD_TWO_MIN  = 8'hC2;
    localparam logic [7:0] LEAD_TWO_MAX  = 8'hDF;
    localparam logic [7:0] LEAD_E0       = 8'hE0;
    localparam logic [7:0] LEAD_ED       = 8'hED;
    localparam logic [7:0] LEAD_THREE_MAX = 8'hEF;
    localparam logic [7:0] LEAD_F0       = 8'hF0;
    localparam logic [7:0] LEAD_FOUR_MAX = 8'hF4;

    // Default depth of the queue between front and back
    localparam int CMD_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_of_run;
        logic        text_done;
    } out_t;

    // Work for the back end: one or two code units from one input byte
    typedef struct packed {
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        two;
        logic        eot;
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/utf8_to_utf16_transcoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A result reaches the ports via the command queue and the output register.
// Throughput: one byte per cycle; a byte that yields two code units holds the
// output for two beats, absorbed by a CMD_DEPTH-entry queue before full rises.
// Reset (rst_n low, asynchronous) clears the sequence state, the queue and the
// output valid flag; the block is ready as soon as reset is released.

module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
#(
    parameter int CMD_DEPTH_P = CMD_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  wire in_t  item,
    output logic      empty,
    input  wire logic pop,
    output out_t      result
);

    logic accept;
    logic cmd_push;
    cmd_t cmd_data;
    logic cmd_pop;
    cmd_t cmd_head;
    logic cmd_full;
    logic cmd_empty;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    // Classify bytes and track sequences
    u8u16_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd_data (cmd_data)
    );

    // Queue between front and back
    u8u16_cmd_fifo #(
        .DEPTH (CMD_DEPTH_P)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_data),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    // Serialise code units to the output
    u8u16_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== design/u8u16_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8u16_cmd_fifo
    import u8u16_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/u8u16_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front
    import u8u16_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  wire in_t  item,
    output logic      cmd_push,
    output cmd_t      cmd_data
);

    logic [1:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  lead_value_reg, lead_value_next;
    logic        first_follow_reg, first_follow_next;
    logic [20:0] partial_reg, partial_next;

    logic [7:0]  b;
    logic        eot;
    logic        follow_ok;
    logic        lead_emit;
    logic [15:0] lead_unit;
    logic [1:0]  lead_need;
    logic [20:0] lead_partial;
    logic [20:0] point;
    logic [19:0] supp_off;
    logic        is_supp;
    logic [1:0]  n_units;

    assign b   = item.in_byte;
    assign eot = item.end_of_text;

    // Continuation check, narrowed after special leads
    always_comb
    begin
        follow_ok = (b[7:6] == 2'b10);
        if (first_follow_reg)
        begin
            if (lead_value_reg == LEAD_E0 && b < 8'hA0)
            begin
                follow_ok = 1'b0;
            end
            if (lead_value_reg == LEAD_ED && b >= 8'hA0)
            begin
                follow_ok = 1'b0;
            end
            if (lead_value_reg == LEAD_F0 && b < 8'h90)
            begin
                follow_ok = 1'b0;
            end
            if (lead_value_reg == LEAD_FOUR_MAX && b >= 8'h90)
            begin
                follow_ok = 1'b0;
            end
        end
    end

    // Lead byte classification
    always_comb
    begin
        lead_need    = 2'd0;
        lead_emit    = 1'b0;
        lead_unit    = REPL_CHAR;
        lead_partial = '0;
        case (b) inside
            [8'h00:ASCII_MAX]:
            begin
                lead_emit = 1'b1;
                lead_unit = {8'h00, b};
            end
            [LEAD_TWO_MIN:LEAD_TWO_MAX]:
            begin
                lead_need    = 2'd1;
                lead_partial = {16'h0, b[4:0]};
            end
            [LEAD_E0:LEAD_THREE_MAX]:
            begin
                lead_need    = 2'd2;
                lead_partial = {17'h0, b[3:0]};
            end
            [LEAD_F0:LEAD_FOUR_MAX]:
            begin
                lead_need    = 2'd3;
                lead_partial = {18'h0, b[2:0]};
            end
            default:
            begin
                lead_emit = 1'b1;
            end
        endcase
        // a sequence start on the last byte is cut off at once
        if (lead_need != 2'd0 && eot)
        begin
            lead_emit = 1'b1;
            lead_need = 2'd0;
        end
    end

    // Completed code point and its surrogate split
    assign point    = {partial_reg[14:0], b[5:0]};
    assign is_supp  = (point >= SUPP_BASE);
    assign supp_off = 20'(point - SUPP_BASE);

    // Sequence state and the command for the back end
    always_comb
    begin
        bytes_left_next   = bytes_left_reg;
        lead_value_next   = lead_value_reg;
        first_follow_next = first_follow_reg;
        partial_next      = partial_reg;
        n_units           = 2'd0;
        cmd_data.unit0    = REPL_CHAR;
        cmd_data.unit1    = REPL_CHAR;
        cmd_data.eot      = eot;

        if (bytes_left_reg != 2'd0 && follow_ok)
        begin
            if (bytes_left_reg == 2'd1)
            begin
                // sequence complete
                bytes_left_next   = 2'd0;
                lead_value_next   = '0;
                first_follow_next = 1'b0;
                partial_next      = '0;
                if (is_supp)
                begin
                    n_units        = 2'd2;
                    cmd_data.unit0 = HIGH_SURR_BASE + {6'h0, supp_off[19:10]};
                    cmd_data.unit1 = LOW_SURR_BASE + {6'h0, supp_off[9:0]};
                end
                else
                begin
                    n_units        = 2'd1;
                    cmd_data.unit0 = point[15:0];
                end
            end
            else if (eot)
            begin
                // cut off by end of text
                n_units           = 2'd1;
                bytes_left_next   = 2'd0;
                lead_value_next   = '0;
                first_follow_next = 1'b0;
                partial_next      = '0;
            end
            else
            begin
                bytes_left_next   = bytes_left_reg - 2'd1;
                first_follow_next = 1'b0;
                partial_next      = point;
            end
        end
        else
        begin
            // bad continuation flushes one replacement, then the byte is a lead
            if (bytes_left_reg != 2'd0)
            begin
                n_units        = 2'd1;
                cmd_data.unit1 = lead_unit;
                if (lead_emit)
                begin
                    n_units = 2'd2;
                end
            end
            else if (lead_emit)
            begin
                n_units        = 2'd1;
                cmd_data.unit0 = lead_unit;
            end
            if (lead_need != 2'd0)
            begin
                bytes_left_next   = lead_need;
                lead_value_next   = b;
                first_follow_next = 1'b1;
                partial_next      = lead_partial;
            end
            else
            begin
                bytes_left_next   = 2'd0;
                lead_value_next   = '0;
                first_follow_next = 1'b0;
                partial_next      = '0;
            end
        end
        cmd_data.two = (n_units == 2'd2);
    end

    assign cmd_push = accept && (n_units != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg   <= '0;
            lead_value_reg   <= '0;
            first_follow_reg <= 1'b0;
            partial_reg      <= '0;
        end
        else if (accept)
        begin
            bytes_left_reg   <= bytes_left_next;
            lead_value_reg   <= lead_value_next;
            first_follow_reg <= first_follow_next;
            partial_reg      <= partial_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/u8u16_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_to_utf16_transcoder_defines.svh"

module u8u16_back
    import u8u16_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_empty,
    input  wire cmd_t cmd_head,
    output logic      cmd_pop,
    input  wire logic pop,
    output logic      empty,
    output out_t      result
);

    logic  out_valid_reg, out_valid_next;
    out_t  result_reg, result_next;
    logic  phase_reg, phase_next;
    logic  load_en;
    logic  is_last;

    // Load the output register from the queue head when it is free or being drained
    assign load_en = !cmd_empty && (!out_valid_reg || pop);
    assign is_last = phase_reg || !cmd_head.two;
    assign cmd_pop = load_en && is_last;

    always_comb
    begin
        result_next             = result_reg;
        phase_next              = phase_reg;
        out_valid_next          = out_valid_reg;
        if (load_en)
        begin
            result_next.code_unit   = phase_reg ? cmd_head.unit1 : cmd_head.unit0;
            result_next.last_of_run = is_last;
            result_next.text_done   = is_last && cmd_head.eot;
            phase_next              = !is_last;
            out_valid_next          = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

    // Checks
    `U8U16_ASSERT_IMPL(a_phase_has_pair, phase_reg, !cmd_empty && cmd_head.two,
        "second unit pending without a two-unit command")
    `U8U16_ASSERT_IMPL(a_pop_needs_load, cmd_pop, load_en,
        "command dropped without reaching the output")
    `U8U16_ASSERT_NEXT(a_pair_second_beat, load_en && cmd_head.two && !phase_reg,
        phase_reg && !cmd_empty,
        "first half of a pair not followed by the second")
    `U8U16_ASSERT_IMPL(a_done_is_last, out_valid_reg && result_reg.text_done,
        result_reg.last_of_run, "end of text flagged on a non-final unit")

endmodule

`default_nettype wire

// ===== sim/tb_utf8_to_utf16_transcoder.sv =====
`timescale 1ns / 1ps

module tb_utf8_to_utf16_transcoder;
    import u8u16_pkg::*;

    // Cycles without any beat before the run is declared hung
    localparam int QUIET_LIMIT = 5000;
    localparam int BYTE_BUDGET = 380;

    // Tracks the decoder state and holds the code units still owed by the block
    class utf16_scoreboard;
        out_t        owed_units[$];
        int unsigned errors;
        logic [1:0]  cont_left;
        logic [7:0]  seq_lead;
        logic        first_cont;
        logic [20:0] code_point;
        logic [15:0] byte_units[$];

        function new();
            errors = 0;
            clear_seq();
        endfunction

        function void clear_seq();
            cont_left  = '0;
            seq_lead   = '0;
            first_cont = 1'b0;
            code_point = '0;
        endfunction

        // Appends one code unit caused by the current byte
        function void add_unit(logic [15:0] u);
            byte_units.insert(byte_units.size(), u);
        endfunction

        // Continuation range, narrowed on the second byte after E0, ED, F0, F4
        function bit cont_ok(logic [7:0] b);
            if (b[7:6] != 2'b10)
                return 1'b0;
            if (first_cont)
            begin
                if (seq_lead == LEAD_E0 && b < 8'hA0) return 1'b0;
                if (seq_lead == LEAD_ED && b >= 8'hA0) return 1'b0;
                if (seq_lead == LEAD_F0 && b < 8'h90) return 1'b0;
                if (seq_lead == LEAD_FOUR_MAX && b >= 8'h90) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void start_seq(logic [7:0] b, logic eot);
            logic [1:0] need;
            if (b <= ASCII_MAX)
            begin
                add_unit({8'h00, b});
                return;
            end
            if (b >= LEAD_TWO_MIN && b <= LEAD_TWO_MAX)
                need = 2'd1;
            else if (b >= LEAD_E0 && b <= LEAD_THREE_MAX)
                need = 2'd2;
            else if (b >= LEAD_F0 && b <= LEAD_FOUR_MAX)
                need = 2'd3;
            else
            begin
                add_unit(REPL_CHAR);
                return;
            end
            // a lead on the last byte of the text is cut off at once
            if (eot)
            begin
                add_unit(REPL_CHAR);
                clear_seq();
                return;
            end
            cont_left  = need;
            seq_lead   = b;
            first_cont = 1'b1;
            code_point = 21'(b) & ((21'd1 << (6 - need)) - 21'd1);
        endfunction

        // Works out the code units that one accepted byte causes
        function void note_byte(in_t beat);
            logic [19:0] offset;
            out_t        unit;
            byte_units.delete();
            if (cont_left != 0)
            begin
                if (cont_ok(beat.in_byte))
                begin
                    code_point = {code_point[14:0], beat.in_byte[5:0]};
                    cont_left  = cont_left - 2'd1;
                    first_cont = 1'b0;
                    if (cont_left == 0)
                    begin
                        if (code_point < SUPP_BASE)
                            add_unit(code_point[15:0]);
                        else
                        begin
                            offset = 20'(code_point - SUPP_BASE);
                            add_unit(HIGH_SURR_BASE + 16'(offset[19:10]));
                            add_unit(LOW_SURR_BASE + 16'(offset[9:0]));
                        end
                        clear_seq();
                    end
                    else if (beat.end_of_text)
                    begin
                        add_unit(REPL_CHAR);
                        clear_seq();
                    end
                end
                else
                begin
                    // broken sequence: replace it, then treat the byte as a lead
                    add_unit(REPL_CHAR);
                    clear_seq();
                    start_seq(beat.in_byte, beat.end_of_text);
                end
            end
            else
                start_seq(beat.in_byte, beat.end_of_text);

            foreach (byte_units[i])
            begin
                unit.code_unit   = byte_units[i];
                unit.last_of_run = (i == byte_units.size() - 1);
                unit.text_done   = (i == byte_units.size() - 1) && beat.end_of_text;
                owed_units.insert(owed_units.size(), unit);
            end
        endfunction

        function void check_unit(out_t got);
            out_t want;
            if (owed_units.size() == 0)
            begin
                $display("%0t: code unit %h last %b done %b with none expected",
                         $time, got.code_unit, got.last_of_run, got.text_done);
                errors++;
                return;
            end
            want = owed_units.pop_front();
            if (got.code_unit !== want.code_unit || got.last_of_run !== want.last_of_run
                    || got.text_done !== want.text_done)
            begin
                $display("%0t: expected unit %h last %b done %b, got unit %h last %b done %b",
                         $time, want.code_unit, want.last_of_run, want.text_done,
                         got.code_unit, got.last_of_run, got.text_done);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    in_t  item = '0;
    logic empty;
    logic pop = 1'b0;
    out_t result;

    utf16_scoreboard board;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          bytes_sent = 0;
    int          quiet_cycles = 0;
    logic [7:0]  text_buf[$];

    utf8_to_utf16_transcoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #2 clk = ~clk;

    // Beat monitor, receiver stalls and hang watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                board.note_byte(item);
            if (pop && !empty)
                board.check_unit(result);
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("tb_utf8_to_utf16_transcoder failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // One byte, with random idle cycles ahead of it, held until taken
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= '{in_byte: b, end_of_text: eot};
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
    endtask

    // Sends the buffered text, end flag on its final byte
    task automatic send_text();
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    // Appends one byte to the text being built
    function automatic void add_byte(logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    function automatic void add_point(logic [20:0] cp);
        if (cp < 21'h80)
            add_byte(cp[7:0]);
        else if (cp < 21'h800)
        begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
        else
        begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
    endfunction

    function automatic logic [20:0] pick_point();
        logic [20:0] cp;
        case ($urandom_range(3))
            0: cp = 21'($urandom_range(8'h7F));
            1: cp = 21'($urandom_range(16'h7FF, 16'h80));
            2:
            begin
                cp = 21'($urandom_range(16'hFFFF, 16'h800));
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp - 21'h1000;
            end
            default: cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
        endcase
        return cp;
    endfunction

    // Mostly well-formed text, with cut sequences, narrowed leads and noise
    function automatic void build_text();
        int chars;
        int start;
        int cut;
        chars = $urandom_range(10, 1);
        repeat (chars)
        begin
            case ($urandom_range(99)) inside
                [0:64]: add_point(pick_point());
                [65:76]:
                begin
                    start = text_buf.size();
                    add_point(pick_point());
                    if (text_buf.size() - start > 1)
                    begin
                        cut = $urandom_range(text_buf.size() - start - 1, 1);
                        repeat (cut) text_buf.delete(text_buf.size() - 1);
                    end
                end
                [77:86]:
                begin
                    case ($urandom_range(3))
                        0: add_byte(LEAD_E0);
                        1: add_byte(LEAD_ED);
                        2: add_byte(LEAD_F0);
                        default: add_byte(LEAD_FOUR_MAX);
                    endcase
                    repeat ($urandom_range(3, 1))
                        add_byte(8'($urandom_range(8'hBF, 8'h80)));
                end
                default: add_byte(8'($urandom_range(8'hFF)));
            endcase
        end
    endfunction

    task automatic run_phase(input int idle, input int stall, input int count);
        int stop_at;
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            build_text();
            send_text();
        end
    endtask

    initial
    begin
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, surrogate pairs, narrowed second bytes,
        // invalid leads, broken and cut-off sequences
        text_buf = '{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'hA0};
        send_text();
        text_buf = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h80, 8'hC1, 8'hF5, 8'hFF};
        send_text();
        text_buf = '{8'hF0, 8'h8F, 8'hE1, 8'h80};
        send_text();
        text_buf = '{8'hC2};
        send_text();
        text_buf = '{8'hF0, 8'h90, 8'h80, 8'h80};
        send_text();

        run_phase(0, 0, BYTE_BUDGET / 4);
        run_phase(77, 0, BYTE_BUDGET / 4);
        run_phase(0, 77, BYTE_BUDGET / 4);
        run_phase(7, 7, BYTE_BUDGET / 4);
        push <= 1'b0;

        // Drain, then a short tail to catch stray units
        while (board.owed_units.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("tb_utf8_to_utf16_transcoder passed");
        else
            $display("tb_utf8_to_utf16_transcoder failed");
        $finish;
    end

endmodule
